// ----- sv/biou_pkg.sv -----
// ============================================================================
// biou_pkg: shared types and constants for the box IoU best-match block
// Item opcodes, controller states and the command/status bundles that join
// the controller to the datapath.
// ============================================================================
`default_nettype none

package biou_pkg;

   localparam int THR_W     = 16;
   localparam int OUT_IDX_W = 5;
   localparam logic [THR_W-1:0] THR_RESET = 16'd19661;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ISSUE,
      ST_GAP,
      ST_DRAIN,
      ST_THRESH,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic capture;
      logic area;
      logic read;
      logic thresh;
      logic reply;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic last_read;
      logic pipe_busy;
   } status_type;

endpackage

`default_nettype wire

// ----- sv/biou_ram.sv -----
// ============================================================================
// biou_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module biou_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/biou_ctrl.sv -----
// ============================================================================
// biou_ctrl: sequencer for the box IoU best-match block
// Decodes items, walks the reference store with a GAP state between reads,
// then runs the threshold test and issues the reply.
// ============================================================================
`default_nettype none

module biou_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           req_op,
   input  wire biou_pkg::status_type status,
   output logic                      busy,
   output biou_pkg::cmd_type         cmd
);

   import biou_pkg::*;

   state_type state_ff, state_in;
   op_type    op;

   assign op = op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && op == OP_QUERY) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP:  state_in = status.empty ? ST_DRAIN : ST_ISSUE;
         ST_ISSUE:  state_in = status.last_read ? ST_DRAIN : ST_GAP;
         ST_GAP:    state_in = ST_ISSUE;
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_THRESH;
            end
         end
         ST_THRESH: state_in = ST_REPLY;
         ST_REPLY:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (op)
                  OP_CLEAR: cmd.clear   = 1'b1;
                  OP_LOAD:  cmd.load    = 1'b1;
                  OP_QUERY: cmd.capture = 1'b1;
                  default:  ;
               endcase
            end
         end
         ST_SETUP:  cmd.area   = 1'b1;
         ST_ISSUE:  cmd.read   = 1'b1;
         ST_GAP:    ;
         ST_DRAIN:  ;
         ST_THRESH: cmd.thresh = 1'b1;
         ST_REPLY:  cmd.reply  = 1'b1;
         default:   ;
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/biou_dpath.sv -----
// ============================================================================
// biou_dpath: datapath for the box IoU best-match block
// Reference store, overlap pipeline, exact cross-multiplied best-match
// compare and threshold test, threshold register and result registers.
// ============================================================================
`default_nettype none

module biou_dpath #(
   parameter int MAX_REFS   = 32,
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire biou_pkg::cmd_type            cmd,
   output biou_pkg::status_type              status,
   input  wire logic signed [COORD_BITS-1:0] req_x_min,
   input  wire logic signed [COORD_BITS-1:0] req_y_min,
   input  wire logic signed [COORD_BITS-1:0] req_x_max,
   input  wire logic signed [COORD_BITS-1:0] req_y_max,
   input  wire logic                         csr_we,
   input  wire logic [biou_pkg::THR_W-1:0]   csr_wdata,
   output logic                              rsp_strobe,
   output logic                              rsp_matched,
   output logic [biou_pkg::OUT_IDX_W-1:0]    rsp_best_index
);

   import biou_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int CW = $clog2(MAX_REFS + 1);
   localparam int BW = 4 * C;
   localparam int IW = 2 * C;          // intersection, unsigned
   localparam int AR = 2 * C + 2;      // area, signed
   localparam int UW = 2 * C + 2;      // positive union, unsigned
   localparam int H  = (UW + 1) / 2;   // low half of a union operand
   localparam int HW = UW - H;
   localparam int PW = IW + UW;
   localparam int TW = UW + THR_W;

   // ---- store and count ----
   logic [CW-1:0]        count_ff;
   logic [AW-1:0]        walk_idx_ff;
   logic [BW-1:0]        rd_data;
   logic                 wr_en;

   assign wr_en = cmd.load && (count_ff != CW'(MAX_REFS));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         walk_idx_ff <= '0;
      end else if (cmd.read) begin
         walk_idx_ff <= walk_idx_ff + AW'(1);
      end
   end

   biou_ram #(
      .WIDTH (BW),
      .DEPTH (MAX_REFS)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_y_max, req_x_max, req_y_min, req_x_min}),
      .rd_en   (cmd.read),
      .rd_addr (walk_idx_ff),
      .rd_data (rd_data)
   );

   // ---- threshold register ----
   logic [THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // ---- query box ----
   logic signed [C-1:0]  q_x0_ff, q_y0_ff, q_x1_ff, q_y1_ff;
   logic signed [C:0]    qdx_ff, qdy_ff;
   logic signed [AR-1:0] qa_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         q_x0_ff <= req_x_min;
         q_y0_ff <= req_y_min;
         q_x1_ff <= req_x_max;
         q_y1_ff <= req_y_max;
         qdx_ff  <= {req_x_max[C-1], req_x_max} - {req_x_min[C-1], req_x_min};
         qdy_ff  <= {req_y_max[C-1], req_y_max} - {req_y_min[C-1], req_y_min};
      end
      if (cmd.area) begin
         qa_ff <= qdx_ff * qdy_ff;
      end
   end

   // ---- pipeline valids ----
   logic rd_vld_ff, s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic cand_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.read;
         s1_vld_ff <= rd_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff && cand_ok_ff;
      end
   end

   // ---- stage 1: edges of the overlap and of the reference box ----
   logic signed [C-1:0] r_x0, r_y0, r_x1, r_y1;
   logic signed [C-1:0] ix0, iy0, ix1, iy1;
   logic signed [C:0]   iw_s, ih_s;
   logic [C-1:0]        iw_ff, ih_ff;
   logic signed [C:0]   rdx_ff, rdy_ff;
   logic [AW-1:0]       rd_idx_ff, s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;

   assign r_x0 = rd_data[C-1:0];
   assign r_y0 = rd_data[2*C-1:C];
   assign r_x1 = rd_data[3*C-1:2*C];
   assign r_y1 = rd_data[4*C-1:3*C];

   assign ix0  = (q_x0_ff > r_x0) ? q_x0_ff : r_x0;
   assign iy0  = (q_y0_ff > r_y0) ? q_y0_ff : r_y0;
   assign ix1  = (q_x1_ff < r_x1) ? q_x1_ff : r_x1;
   assign iy1  = (q_y1_ff < r_y1) ? q_y1_ff : r_y1;
   assign iw_s = {ix1[C-1], ix1} - {ix0[C-1], ix0};
   assign ih_s = {iy1[C-1], iy1} - {iy0[C-1], iy0};

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_idx_ff <= walk_idx_ff;
      end
      if (rd_vld_ff) begin
         iw_ff     <= iw_s[C] ? '0 : iw_s[C-1:0];
         ih_ff     <= ih_s[C] ? '0 : ih_s[C-1:0];
         rdx_ff    <= {r_x1[C-1], r_x1} - {r_x0[C-1], r_x0};
         rdy_ff    <= {r_y1[C-1], r_y1} - {r_y0[C-1], r_y0};
         s1_idx_ff <= rd_idx_ff;
      end
   end

   // ---- stage 2: intersection and reference area ----
   logic [IW-1:0]        inter_ff;
   logic signed [AR-1:0] ra_ff;

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         inter_ff  <= iw_ff * ih_ff;
         ra_ff     <= rdx_ff * rdy_ff;
         s2_idx_ff <= s1_idx_ff;
      end
   end

   // ---- stage 3: union and candidate ----
   logic signed [AR:0] uni;
   logic [IW-1:0]      cand_i_ff;
   logic [UW-1:0]      cand_u_ff;

   assign uni = {qa_ff[AR-1], qa_ff} + {ra_ff[AR-1], ra_ff} - (AR+1)'(inter_ff);

   always_ff @(posedge clock) begin
      if (s2_vld_ff) begin
         cand_i_ff  <= inter_ff;
         cand_u_ff  <= uni[UW-1:0];
         cand_ok_ff <= !uni[AR] && (uni != '0) && (inter_ff != '0);
         s3_idx_ff  <= s2_idx_ff;
      end
   end

   // ---- stage 4: partial products against the current best ----
   logic [IW-1:0]    best_i_ff;
   logic [UW-1:0]    best_u_ff;
   logic [AW-1:0]    top_idx_ff;
   logic             found_ff;
   logic [IW+H-1:0]  pa_lo_ff, pb_lo_ff;
   logic [IW+HW-1:0] pa_hi_ff, pb_hi_ff;

   always_ff @(posedge clock) begin
      if (s3_vld_ff) begin
         pa_lo_ff  <= cand_i_ff * best_u_ff[H-1:0];
         pa_hi_ff  <= cand_i_ff * best_u_ff[UW-1:H];
         pb_lo_ff  <= best_i_ff * cand_u_ff[H-1:0];
         pb_hi_ff  <= best_i_ff * cand_u_ff[UW-1:H];
         s4_idx_ff <= s3_idx_ff;
      end
   end

   // ---- stage 5: strict compare and best update ----
   logic [PW-1:0] lhs, rhs;
   logic          beats;

   assign lhs   = {pa_hi_ff, {H{1'b0}}} + PW'(pa_lo_ff);
   assign rhs   = {pb_hi_ff, {H{1'b0}}} + PW'(pb_lo_ff);
   assign beats = s4_vld_ff && (lhs > rhs);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         best_i_ff  <= '0;
         best_u_ff  <= UW'(1);
         top_idx_ff <= '0;
         found_ff   <= 1'b0;
      end else if (beats) begin
         best_i_ff  <= cand_i_ff;
         best_u_ff  <= cand_u_ff;
         top_idx_ff <= s4_idx_ff;
         found_ff   <= 1'b1;
      end
   end

   // ---- threshold test and result ----
   logic [TW-1:0]           thr_prod_ff;
   logic [TW-1:0]           best_scaled;
   logic [AW+OUT_IDX_W-1:0] idx_ext;
   logic                    rsp_strobe_ff;
   logic                    rsp_matched_ff;
   logic [OUT_IDX_W-1:0]    rsp_best_index_ff;

   assign best_scaled = TW'({best_i_ff, {THR_W{1'b0}}});
   assign idx_ext     = {{OUT_IDX_W{1'b0}}, top_idx_ff};

   always_ff @(posedge clock) begin
      if (cmd.thresh) begin
         thr_prod_ff <= thr_ff * best_u_ff;
      end
      if (cmd.reply) begin
         rsp_matched_ff    <= found_ff && (best_scaled >= thr_prod_ff);
         rsp_best_index_ff <= found_ff ? idx_ext[OUT_IDX_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.reply;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_matched    = rsp_matched_ff;
   assign rsp_best_index = rsp_best_index_ff;

   // ---- status ----
   assign status.empty     = (count_ff == '0);
   assign status.last_read = ((CW'(walk_idx_ff) + CW'(1)) == count_ff);
   assign status.pipe_busy = rd_vld_ff || s1_vld_ff || s2_vld_ff || s3_vld_ff
                             || s4_vld_ff;

endmodule

`default_nettype wire

// ----- sv/box_iou_best_match_top.sv -----
// ============================================================================
// box_iou_best_match_top: box IoU best-match association
// Stores reference boxes, and for each query box finds the stored box with
// the greatest intersection-over-union and tests it against a threshold.
//
//   channel  direction  handshake           payload
//   req      in         start, busy         req_op, req_x_min, req_y_min,
//                                           req_x_max, req_y_max
//   rsp      out        rsp_strobe          rsp_matched, rsp_best_index
//   csr      in         csr_we              csr_wdata (iou threshold, Q0.16)
//
// Clear and load items are taken in the idle state; busy stays low.
// A query holds busy high until its reply; busy falls at the same edge at
// which rsp_strobe rises. The running best-match compare forms partial
// products against the current best, then compares and updates the best.
// Reset is synchronous; it empties the store and restores the threshold.
// rsp_strobe is high for one cycle; the receiver cannot stall it.
// ============================================================================
`default_nettype none

module box_iou_best_match_top #(
   parameter int MAX_REFS   = 32,
   parameter int COORD_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_op,
   input  wire logic signed [COORD_BITS-1:0]  req_x_min,
   input  wire logic signed [COORD_BITS-1:0]  req_y_min,
   input  wire logic signed [COORD_BITS-1:0]  req_x_max,
   input  wire logic signed [COORD_BITS-1:0]  req_y_max,
   input  wire logic                          csr_we,
   input  wire logic [biou_pkg::THR_W-1:0]    csr_wdata,
   output logic                               rsp_strobe,
   output logic                               rsp_matched,
   output logic [biou_pkg::OUT_IDX_W-1:0]     rsp_best_index
);

   import biou_pkg::*;

   cmd_type    cmd;
   status_type status;

   biou_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   biou_dpath #(
      .MAX_REFS   (MAX_REFS),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_x_min      (req_x_min),
      .req_y_min      (req_y_min),
      .req_x_max      (req_x_max),
      .req_y_max      (req_y_max),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_matched    (rsp_matched),
      .rsp_best_index (rsp_best_index)
   );

endmodule

`default_nettype wire
